// ----- hw/rtl/nearest_object_track_merge_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the nearest object track merge block
// Shorthand for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef NEAREST_OBJECT_TRACK_MERGE_ASSERT_SVH
`define NEAREST_OBJECT_TRACK_MERGE_ASSERT_SVH

// Same-cycle implication.
`define NOM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("nom check failed");

// Next-cycle implication.
`define NOM_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("nom check failed");

`endif

// ----- hw/rtl/nom_pkg.sv -----
// ----------------------------------------------------------------------------
// nom_pkg
// Shared widths, codes and types of the nearest object track merge block.
// ----------------------------------------------------------------------------
package nom_pkg;

    localparam int CFG_W   = 18;
    localparam int KIND_W  = 3;
    localparam int COLOR_W = 3;
    localparam int CLASS_W = KIND_W + COLOR_W;
    localparam int SLOT_W  = 6;
    localparam int SQ_W    = 2 * CFG_W;
    localparam int D2_W    = SQ_W + 2;

    localparam logic [KIND_W-1:0] KIND_CONDUCTOR = 3'd1;
    localparam logic [CFG_W-1:0]  MATCH_DIST_RST = 18'd500;

    typedef struct packed {
        logic vld;
        logic last;
    } nom_ctl_t;

endpackage

// ----- hw/rtl/nom_cell.sv -----
// ----------------------------------------------------------------------------
// nom_cell
// One table entry of the rotating ring; loads from its neighbor or a write.
// ----------------------------------------------------------------------------
module nom_cell #(
    parameter int EW = 78
) (
    input  logic          aclk,
    input  logic          shift_en,
    input  logic          wr_en,
    input  logic [EW-1:0] wr_data,
    input  logic [EW-1:0] nb_data,
    output logic [EW-1:0] q
);
    logic [EW-1:0] q_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            q_reg <= wr_data;
        end else if (shift_en) begin
            q_reg <= nb_data;
        end
    end

    assign q = q_reg;
endmodule

// ----- hw/rtl/nom_dist.sv -----
// ----------------------------------------------------------------------------
// nom_dist
// Three-stage distance test of the ring head entry against the observation.
// ----------------------------------------------------------------------------
module nom_dist #(
    parameter int P  = 18,
    parameter int EW = 78,
    parameter int IW = 6
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  nom_pkg::nom_ctl_t          in_ctl,
    input  logic [IW-1:0]              in_idx,
    input  logic [EW-1:0]              head,
    input  logic [EW-1:0]              obs,
    input  logic [nom_pkg::CFG_W-1:0]  cut,
    input  logic [nom_pkg::SQ_W-1:0]   cut2,
    output nom_pkg::nom_ctl_t          out_ctl,
    output logic [nom_pkg::D2_W-1:0]   out_d2,
    output logic [IW-1:0]              out_idx,
    output logic [EW-1:0]              out_ent
);
    import nom_pkg::*;

    localparam int EX   = CLASS_W;
    localparam int CMPW = (P + 1 > CFG_W) ? P + 1 : CFG_W;

    logic [P:0]   mag_x, mag_y, mag_z;
    logic         near;
    nom_ctl_t     ctl1_reg, ctl2_reg, ctl3_reg;
    logic [IW-1:0] idx1_reg, idx2_reg, idx3_reg;
    logic [EW-1:0] ent1_reg, ent2_reg, ent3_reg;
    logic [CFG_W-1:0] mx_reg, my_reg, mz_reg;
    logic [SQ_W-1:0]  sx_reg, sy_reg, sz_reg;
    logic [D2_W-1:0]  d2_reg, sum;

    function automatic logic [P:0] absdiff(input logic [P-1:0] a, input logic [P-1:0] b);
        logic [P:0] d;
        d = {a[P-1], a} - {b[P-1], b};
        return d[P] ? -d : d;
    endfunction

    always_comb begin
        mag_x = absdiff(head[EX +: P], obs[EX +: P]);
        mag_y = absdiff(head[EX+P +: P], obs[EX+P +: P]);
        mag_z = absdiff(head[EX+2*P +: P], obs[EX+2*P +: P]);
        near  = (CMPW'(mag_x) < CMPW'(cut)) && (CMPW'(mag_y) < CMPW'(cut))
             && (CMPW'(mag_z) < CMPW'(cut));
        sum   = D2_W'(sx_reg) + D2_W'(sy_reg) + D2_W'(sz_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end else begin
            ctl1_reg.vld  <= in_ctl.vld && near
                          && (head[CLASS_W-1:0] == obs[CLASS_W-1:0]);
            ctl1_reg.last <= in_ctl.last;
            ctl2_reg      <= ctl1_reg;
            ctl3_reg.vld  <= ctl2_reg.vld && (sum < D2_W'(cut2));
            ctl3_reg.last <= ctl2_reg.last;
        end
    end

    // square only matters when near, so the cutoff width holds the magnitude
    always_ff @(posedge aclk) begin
        idx1_reg <= in_idx;
        ent1_reg <= head;
        mx_reg   <= CFG_W'(mag_x);
        my_reg   <= CFG_W'(mag_y);
        mz_reg   <= CFG_W'(mag_z);
        idx2_reg <= idx1_reg;
        ent2_reg <= ent1_reg;
        sx_reg   <= mx_reg * mx_reg;
        sy_reg   <= my_reg * my_reg;
        sz_reg   <= mz_reg * mz_reg;
        idx3_reg <= idx2_reg;
        ent3_reg <= ent2_reg;
        d2_reg   <= sum;
    end

    assign out_ctl = ctl3_reg;
    assign out_d2  = d2_reg;
    assign out_idx = idx3_reg;
    assign out_ent = ent3_reg;
endmodule

// ----- hw/rtl/nearest_object_track_merge.sv -----
// ----------------------------------------------------------------------------
// nearest_object_track_merge
// Nearest-neighbor association of observed objects into a bounded table.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one observation per transfer; s_tuser = kind, s_tdata =
//   color, x, y, z, heading. m_ channel: one result per observation;
//   m_tuser = matched, table_full, kind; m_tdata = slot, color, x, y, z,
//   heading. cfg_ channel: writes the match distance, always ready; write
//   only while the block is idle.
//   The table lives in a ring of MAX_OBJECTS cells that rotates once per
//   observation past a three-stage distance unit at its head. The result
//   is registered after the scan and the drain of the unit, and the next
//   item is taken once the previous one has been written.
//   The ring scan passes one stored entry per cycle.
//   Reset empties the table (count zero) and sets the cutoff to 500.
//   When the receiver stalls, the result holds in the output register and
//   the block waits before writing the table for the next item.
// ----------------------------------------------------------------------------
module nearest_object_track_merge #(
    parameter int MAX_OBJECTS = 64,
    parameter int POS_BITS    = 18,
    parameter int ANGLE_BITS  = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // obj_color, pos_x, pos_y, pos_z, heading, zero fill
    input  logic [((3+3*POS_BITS+ANGLE_BITS+7)/8)*8-1:0] s_tdata,
    // obj_kind
    input  logic [2:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // slot, res_color, res_x, res_y, res_z, res_heading, zero fill
    output logic [((9+3*POS_BITS+ANGLE_BITS+7)/8)*8-1:0] m_tdata,
    // matched, table_full, res_kind
    output logic [4:0] m_tuser,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [nom_pkg::CFG_W-1:0] cfg_data
);
    import nom_pkg::*;

    localparam int N    = MAX_OBJECTS;
    localparam int P    = POS_BITS;
    localparam int A    = ANGLE_BITS;
    localparam int IW   = $clog2(N);
    localparam int CNTW = $clog2(N + 1);
    localparam int EW   = CLASS_W + 3 * P + A;
    localparam int EX   = CLASS_W;
    localparam int EH   = CLASS_W + 3 * P;
    localparam int MW   = ((9 + 3 * P + A + 7) / 8) * 8;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_MERGE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CFG_W-1:0]  md_reg;
    logic [SQ_W-1:0]   cut2_reg;
    logic [CNTW-1:0]   count_reg;
    logic [IW-1:0]     scan_reg;
    logic [EW-1:0]     obs_reg;
    logic              found_reg;
    logic [D2_W-1:0]   best_reg;
    logic [IW-1:0]     bidx_reg;
    logic [EW-1:0]     bent_reg;
    logic              m_tvalid_reg;
    logic [MW-1:0]     m_tdata_reg;
    logic [4:0]        m_tuser_reg;

    logic [EW-1:0]     cell_q [N];
    logic [N-1:0]      wr_sel;
    nom_ctl_t          dist_in, dist_out;
    logic [D2_W-1:0]   dist_d2;
    logic [IW-1:0]     dist_idx;
    logic [EW-1:0]     dist_ent;

    logic              s_fire, merge_go, shift_en, room, full, wr_do;
    logic [IW-1:0]     wr_idx;
    logic [EW-1:0]     wr_data, merged;
    logic [P:0]        sx, sy, sz;
    logic [A-1:0]      oh, nh, df, mf, mh;
    logic [A-2:0]      ha, hb, dh, mhs;
    logic [SLOT_W-1:0] slot_v;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign shift_en  = (state_reg == ST_SCAN);
    assign merge_go  = (state_reg == ST_MERGE) && (!m_tvalid_reg || m_tready);

    // the ring: each cell takes its upper neighbor, head cell zero feeds the unit
    for (genvar i = 0; i < N; i++) begin : g_cell
        nom_cell #(.EW(EW)) u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .wr_en    (wr_sel[i]),
            .wr_data  (wr_data),
            .nb_data  (cell_q[(i + 1) % N]),
            .q        (cell_q[i])
        );
        assign wr_sel[i] = merge_go && wr_do && (wr_idx == IW'(i));
    end

    assign dist_in.vld  = shift_en && (CNTW'(scan_reg) < count_reg);
    assign dist_in.last = shift_en && (scan_reg == IW'(N - 1));

    nom_dist #(.P(P), .EW(EW), .IW(IW)) u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_ctl  (dist_in),
        .in_idx  (scan_reg),
        .head    (cell_q[0]),
        .obs     (obs_reg),
        .cut     (md_reg),
        .cut2    (cut2_reg),
        .out_ctl (dist_out),
        .out_d2  (dist_d2),
        .out_idx (dist_idx),
        .out_ent (dist_ent)
    );

    // merge: midpoint of positions, circular mean of headings (over the half turn for conductors)
    always_comb begin
        sx  = {bent_reg[EX+P-1], bent_reg[EX +: P]} + {obs_reg[EX+P-1], obs_reg[EX +: P]};
        sy  = {bent_reg[EX+2*P-1], bent_reg[EX+P +: P]}
            + {obs_reg[EX+2*P-1], obs_reg[EX+P +: P]};
        sz  = {bent_reg[EX+3*P-1], bent_reg[EX+2*P +: P]}
            + {obs_reg[EX+3*P-1], obs_reg[EX+2*P +: P]};
        oh  = bent_reg[EH +: A];
        nh  = obs_reg[EH +: A];
        df  = nh - oh;
        mf  = df[A-1] ? nh + ((-df) >> 1) : oh + (df >> 1);
        ha  = oh[A-2:0];
        hb  = nh[A-2:0];
        dh  = hb - ha;
        mhs = dh[A-2] ? hb + ((-dh) >> 1) : ha + (dh >> 1);
        mh  = A'(mhs);
        merged = {(obs_reg[CLASS_W-1:COLOR_W] == KIND_CONDUCTOR) ? mh : mf,
                  sz[P:1], sy[P:1], sx[P:1], obs_reg[CLASS_W-1:0]};
        room    = count_reg < CNTW'(N);
        full    = !found_reg && !room;
        wr_do   = found_reg || room;
        wr_idx  = found_reg ? bidx_reg : IW'(count_reg);
        wr_data = found_reg ? merged : obs_reg;
        slot_v  = SLOT_W'(wr_idx);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_fire) state_next = ST_SCAN;
            ST_SCAN:  if (scan_reg == IW'(N - 1)) state_next = ST_DRAIN;
            ST_DRAIN: if (dist_out.last) state_next = ST_MERGE;
            ST_MERGE: if (merge_go) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            md_reg       <= MATCH_DIST_RST;
            count_reg    <= '0;
            scan_reg     <= '0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                md_reg <= cfg_data;
            end
            if (s_fire) begin
                scan_reg  <= '0;
                found_reg <= 1'b0;
            end else if (shift_en) begin
                scan_reg <= scan_reg + 1'b1;
            end
            // keep the first of equal distances: strict compare
            if (dist_out.vld && (!found_reg || dist_d2 < best_reg)) begin
                found_reg <= 1'b1;
            end
            if (merge_go && !found_reg && room) begin
                count_reg <= count_reg + 1'b1;
            end
            if (merge_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cut2_reg <= md_reg * md_reg;
        if (s_fire) begin
            obs_reg <= {s_tdata[3+3*P +: A], s_tdata[3 +: 3*P], s_tuser, s_tdata[2:0]};
        end
        if (dist_out.vld && (!found_reg || dist_d2 < best_reg)) begin
            best_reg <= dist_d2;
            bidx_reg <= dist_idx;
            bent_reg <= dist_ent;
        end
        if (merge_go) begin
            if (full) begin
                m_tdata_reg <= '0;
                m_tuser_reg <= {3'b000, 1'b1, 1'b0};
            end else begin
                m_tdata_reg <= MW'({wr_data[EX +: 3*P+A], wr_data[COLOR_W-1:0], slot_v});
                m_tuser_reg <= {wr_data[CLASS_W-1:COLOR_W], 1'b0, found_reg};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
endmodule

// ----- hw/rtl/nom_checker.sv -----
// ----------------------------------------------------------------------------
// nom_checker
// Port-level checks of the nearest object track merge block.
// ----------------------------------------------------------------------------
`include "nearest_object_track_merge_assert.svh"

module nom_checker #(
    parameter int MW = 80
) (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [MW-1:0] m_tdata,
    input logic [4:0]    m_tuser
);
    `NOM_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `NOM_ASSERT_IMP(a_flags_excl, aclk, aresetn, m_tvalid, !(m_tuser[0] && m_tuser[1]))
    `NOM_ASSERT_IMP(a_full_zero, aclk, aresetn, m_tvalid && m_tuser[1], (m_tdata == '0) && (m_tuser[4:2] == 3'd0))
    `NOM_ASSERT_NXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)
endmodule

bind nearest_object_track_merge nom_checker #(.MW(MW)) u_nom_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for nearest_object_track_merge
// Drives observations through the stream input, tracks its own copy of the
// object table to predict each merge, append or drop, and checks every
// result field by field across several cutoffs and handshake idling modes.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nom_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        bit [2:0]  kind;
        bit [2:0]  color;
        longint    x;
        longint    y;
        longint    z;
        bit [15:0] heading;
    } sighting_t;

    typedef struct {
        bit        matched;
        bit        full;
        bit [5:0]  slot;
        bit [2:0]  kind;
        bit [2:0]  color;
        bit [17:0] x;
        bit [17:0] y;
        bit [17:0] z;
        bit [15:0] heading;
    } track_update_t;

    // Scoreboard: own copy of the object table and cutoff, queue of pending updates.
    class track_table_board;
        int unsigned     cutoff;
        int              count;
        bit [5:0]        cls [TABLE_DEPTH];
        longint          tx [TABLE_DEPTH];
        longint          ty [TABLE_DEPTH];
        longint          tz [TABLE_DEPTH];
        bit [15:0]       th [TABLE_DEPTH];
        track_update_t   pending [$];
        int              errors;

        function new();
            cutoff = 32'(MATCH_DIST_RST);
            count  = 0;
            errors = 0;
        endfunction

        function bit [15:0] mean_turn(bit [15:0] o, bit [15:0] n);
            bit [15:0] d;
            d = n - o;
            if (d < 16'h8000) return o + (d >> 1);
            return 16'(n + ((17'h10000 - d) >> 1));
        endfunction

        function bit [15:0] mean_half_turn(bit [15:0] o, bit [15:0] n);
            bit [14:0] a;
            bit [14:0] b;
            bit [14:0] d;
            a = o[14:0];
            b = n[14:0];
            d = b - a;
            if (d < 15'h4000) return {1'b0, a + (d >> 1)};
            return {1'b0, b + 15'((16'h8000 - d) >> 1)};
        endfunction

        // Predict the update caused by one accepted observation.
        function void note_sighting(sighting_t s);
            track_update_t u;
            longint dx, dy, dz, d2, best, cut;
            bit found;
            int best_i;
            bit [5:0] c;
            c = {s.kind, s.color};
            cut = cutoff;
            found = 0;
            best = 0;
            best_i = 0;
            u = '{default: 0};
            for (int i = 0; i < count; i++) begin
                if (cls[i] != c) continue;
                dx = tx[i] - s.x; if (dx < 0) dx = -dx;
                dy = ty[i] - s.y; if (dy < 0) dy = -dy;
                dz = tz[i] - s.z; if (dz < 0) dz = -dz;
                if (dx >= cut || dy >= cut || dz >= cut) continue;
                d2 = dx * dx + dy * dy + dz * dz;
                if (d2 < cut * cut && (!found || d2 < best)) begin
                    found = 1;
                    best = d2;
                    best_i = i;
                end
            end
            if (found) begin
                // floor of the sum over two, by arithmetic shift
                tx[best_i] = (tx[best_i] + s.x) >>> 1;
                ty[best_i] = (ty[best_i] + s.y) >>> 1;
                tz[best_i] = (tz[best_i] + s.z) >>> 1;
                th[best_i] = (s.kind == KIND_CONDUCTOR) ? mean_half_turn(th[best_i], s.heading)
                                                        : mean_turn(th[best_i], s.heading);
                u.matched = 1;
                u.slot = 6'(best_i);
            end else if (count < TABLE_DEPTH) begin
                cls[count] = c;
                tx[count] = s.x;
                ty[count] = s.y;
                tz[count] = s.z;
                th[count] = s.heading;
                u.slot = 6'(count);
                best_i = count;
                count++;
            end else begin
                u.full = 1;
            end
            if (!u.full) begin
                u.kind = s.kind;
                u.color = s.color;
                u.x = tx[best_i][17:0];
                u.y = ty[best_i][17:0];
                u.z = tz[best_i][17:0];
                u.heading = th[best_i];
            end
            pending = {pending, u};
        endfunction

        function void compare(string field, longint unsigned exp_v, longint unsigned act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, exp_v, act_v);
            end
        endfunction

        // Check one result transfer against the oldest pending update.
        function void check_update(bit [4:0] tuser, bit [79:0] tdata);
            track_update_t u;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, user 0x%0h data 0x%0h", $time, tuser, tdata);
                return;
            end
            u = pending.pop_front();
            compare("matched", u.matched, tuser[0]);
            compare("table_full", u.full, tuser[1]);
            compare("res_kind", u.kind, tuser[4:2]);
            compare("slot", u.slot, tdata[5:0]);
            compare("res_color", u.color, tdata[8:6]);
            compare("res_x", u.x, tdata[26:9]);
            compare("res_y", u.y, tdata[44:27]);
            compare("res_z", u.z, tdata[62:45]);
            compare("res_heading", u.heading, tdata[78:63]);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    track_table_board board;
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned cycles;

    nearest_object_track_merge u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Receiver: stall at random per current mode, change on the falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Check every result transfer at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_update(m_tuser, m_tdata);
        end
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** nearest_object_track_merge: FAILED **");
            $finish;
        end
    end

    // Present one observation; hold it until the transfer, idle at random before.
    task automatic send_sighting(sighting_t s);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = s.kind;
        s_tdata  = {7'd0, s.heading, s.z[17:0], s.y[17:0], s.x[17:0], s.color};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        board.note_sighting(s);
    endtask

    task automatic send_at(int k, int c, longint x, longint y, longint z, int h);
        sighting_t s;
        s.kind = 3'(k);
        s.color = 3'(c);
        s.x = x;
        s.y = y;
        s.z = z;
        s.heading = 16'(h);
        send_sighting(s);
    endtask

    // Hold the sender until every pending update has come, then let the scan settle.
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_cutoff(int unsigned value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = CFG_W'(value);
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        board.cutoff = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic longint clip_pos(longint v);
        if (v < -131072) return -131072;
        if (v > 131071) return 131071;
        return v;
    endfunction

    function automatic longint jitter(longint v, int unsigned span);
        return clip_pos(v + longint'($urandom_range(2 * span)) - longint'(span));
    endfunction

    // Mostly sightings near a stored object of the same class; the rest is noise.
    function automatic sighting_t random_sighting();
        sighting_t s;
        int i;
        int unsigned span;
        s.heading = 16'($urandom);
        if (board.count > 0 && $urandom_range(99) < 75) begin
            i = int'($urandom_range(board.count - 1));
            span = (board.cutoff > 3000) ? 3000 : board.cutoff;
            s.kind  = board.cls[i][5:3];
            s.color = board.cls[i][2:0];
            s.x = jitter(board.tx[i], span);
            s.y = jitter(board.ty[i], span);
            s.z = jitter(board.tz[i], span);
        end else begin
            s.kind  = 3'(($urandom_range(9) == 0) ? $urandom_range(7, 5) : $urandom_range(4));
            s.color = 3'(($urandom_range(9) == 0) ? $urandom_range(7, 3) : $urandom_range(2));
            s.x = $signed(18'($urandom));
            s.y = $signed(18'($urandom));
            s.z = $signed(18'($urandom));
        end
        return s;
    endfunction

    int unsigned cutoff_plan [8] = '{500, 262143, 0, 1, 0, 3000, 262143, 40};

    initial begin
        board = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        cycles = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part at the reset cutoff.
        send_at(0, 0, -131072, 131071, 0, 0);          // append at position extremes
        send_at(0, 0, -131072, 131071, 0, 65535);      // exact match, heading wraps
        send_at(1, 2, 0, 0, 0, 32767);                 // conductor
        send_at(1, 2, 1, 1, 1, 100);                   // conductor half-turn mean
        send_at(1, 0, 5000, 5000, 5000, 0);
        send_at(1, 0, 5000, 5000, 5000, 65535);        // half-turn wrap, top bit dropped
        send_at(2, 1, 300, 0, 0, 1000);
        send_at(2, 1, -300, 0, 0, 2000);               // too far from the first: append
        send_at(2, 1, 0, 0, 0, 3000);                  // tie: lowest index wins
        send_at(3, 3, 10000, 10000, 10000, 7);
        send_at(3, 3, 10500, 10000, 10000, 9);         // axis difference equals cutoff
        send_at(3, 3, 10000, 10300, 10400, 11);        // squared distance equals cutoff squared
        send_at(3, 3, 10001, 10001, 10001, 40000);     // nearest of several candidates
        send_at(0, 1, -131072, 131071, 0, 5);          // color differs: no match
        send_at(7, 7, 131071, 131071, 131071, 65535);  // reserved kind and color
        send_at(7, 7, 131070, 131069, 131071, 32768);
        send_at(4, 5, -3, -3, -3, 32768);
        send_at(4, 5, -2, -2, -2, 0);                  // odd negative sum floors
        send_at(5, 6, -131072, -131072, -131072, 1);
        drain();
        write_cutoff(0);
        send_at(5, 6, -131072, -131072, -131072, 2);   // zero cutoff never matches
        drain();

        // Random phases: rotate the cutoff and the idling mode.
        for (int p = 0; p < 8; p++) begin
            write_cutoff((p == 4) ? $urandom_range(262143) : cutoff_plan[p]);
            case (p % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 70; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 70; end
                default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
            endcase
            for (int n = 0; n < 100; n++) begin
                send_sighting(random_sighting());
            end
            drain();
        end

        if (board.errors == 0) begin
            $display("** nearest_object_track_merge: PASSED **");
        end else begin
            $display("** nearest_object_track_merge: FAILED **");
        end
        $finish;
    end
endmodule
